// ===== src/fdvs_pkg.sv =====
// ----------------------------------------------------------------------------
// fdvs_pkg
// Types and constants shared by the variable selection block.
// ----------------------------------------------------------------------------
package fdvs_pkg;

  localparam int SIZE_W = 29;
  localparam int VAL_W  = 28;
  localparam int CSTR_W = 16;
  localparam int IDX_W  = 10;
  localparam int HEUR_W = 3;

  typedef logic [SIZE_W-1:0] size_t;
  typedef logic [VAL_W-1:0]  val_t;
  typedef logic [CSTR_W-1:0] cstr_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [HEUR_W-1:0] heur_t;

  localparam idx_t IDX_MAX = {IDX_W{1'b1}};

  localparam heur_t HEUR_STANDARD   = 3'd0;
  localparam heur_t HEUR_FIRST_FAIL = 3'd1;
  localparam heur_t HEUR_MOST_CSTR  = 3'd2;
  localparam heur_t HEUR_SMALLEST   = 3'd3;
  localparam heur_t HEUR_LARGEST    = 3'd4;
  localparam heur_t HEUR_MAX_REGRET = 3'd5;

  typedef struct packed {
    size_t domain_size;
    val_t  min_value;
    val_t  max_value;
    cstr_t constraint_count;
    val_t  regret_gap;
    logic  is_ground;
    logic  last_var;
  } desc_t;

  typedef struct packed {
    size_t size;
    val_t  min_value;
    val_t  max_value;
    cstr_t constraints;
    val_t  gap;
  } best_t;

  typedef struct packed {
    logic found;
    idx_t index;
  } res_t;

endpackage

// ===== src/fdvs_ifs.sv =====
// ----------------------------------------------------------------------------
// fdvs interfaces
// Request channels for descriptors, results and the heuristic register.
// ----------------------------------------------------------------------------
interface fdvs_in_if;
  logic            valid;
  logic            ready;
  fdvs_pkg::size_t domain_size;
  fdvs_pkg::val_t  min_value;
  fdvs_pkg::val_t  max_value;
  fdvs_pkg::cstr_t constraint_count;
  fdvs_pkg::val_t  regret_gap;
  logic            is_ground;
  logic            last_var;

  modport source (output valid, domain_size, min_value, max_value, constraint_count,
                  regret_gap, is_ground, last_var, input ready);
  modport sink (input valid, domain_size, min_value, max_value, constraint_count,
                regret_gap, is_ground, last_var, output ready);
endinterface

interface fdvs_out_if;
  logic           valid;
  logic           ready;
  logic           found;
  fdvs_pkg::idx_t selected_index;

  modport source (output valid, found, selected_index, input ready);
  modport sink (input valid, found, selected_index, output ready);
endinterface

interface fdvs_cfg_if;
  logic            valid;
  logic            ready;
  fdvs_pkg::heur_t data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ===== src/fd_variable_selection.sv =====
// a last descriptor is registered at the input, then its result in the result register
// throughput: one descriptor per cycle, set by the single compare and update stage
// a result waiting at the output stalls only a following last descriptor
// reset: synchronous, clears the heuristic to standard, position and held candidate
// ----------------------------------------------------------------------------
// fd_variable_selection
// Picks the non-ground variable favored by the configured heuristic.
// ----------------------------------------------------------------------------
module fd_variable_selection #(
  parameter int MAX_VARS = 1024
) (
  input  logic clk,
  input  logic rst,
  fdvs_in_if.sink    in_ch,
  fdvs_out_if.source out_ch,
  fdvs_cfg_if.sink   cfg
);

  fdvs_pkg::heur_t heuristic;
  logic            in_valid_q;
  fdvs_pkg::desc_t in_data;
  logic            advance;
  logic            out_valid;
  fdvs_pkg::res_t  out_data;
  fdvs_pkg::res_t  res;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      heuristic <= fdvs_pkg::HEUR_STANDARD;
    end else if (cfg.valid) begin
      heuristic <= cfg.data;
    end
  end

  // input register
  assign advance     = in_valid_q && (!in_data.last_var || !out_valid || out_ch.ready);
  assign in_ch.ready = !in_valid_q || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_q <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_data.domain_size      <= in_ch.domain_size;
      in_data.min_value        <= in_ch.min_value;
      in_data.max_value        <= in_ch.max_value;
      in_data.constraint_count <= in_ch.constraint_count;
      in_data.regret_gap       <= in_ch.regret_gap;
      in_data.is_ground        <= in_ch.is_ground;
      in_data.last_var         <= in_ch.last_var;
    end
  end

  fdvs_tracker #(
    .MAX_VARS (MAX_VARS)
  ) u_tracker (
    .clk       (clk),
    .rst       (rst),
    .heuristic (heuristic),
    .step      (advance),
    .desc      (in_data),
    .res       (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && in_data.last_var) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_data.last_var) begin
      out_data <= res;
    end
  end

  assign out_ch.valid          = out_valid;
  assign out_ch.found          = out_data.found;
  assign out_ch.selected_index = out_data.index;

`ifndef SYNTH
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (advance && in_data.last_var) |-> (!out_valid || out_ch.ready))
    else $error("pending result overwritten");

  a_empty_index: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.found) |-> (out_data.index == '0))
    else $error("index set with nothing found");

  a_drop_taken: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ch.ready) |=> out_valid)
    else $error("result dropped before it was taken");
`endif

endmodule

// ===== src/fdvs_beats.sv =====
// ----------------------------------------------------------------------------
// fdvs_beats
// Decides whether a descriptor is strictly better than the held candidate.
// ----------------------------------------------------------------------------
module fdvs_beats (
  input  fdvs_pkg::heur_t heuristic,
  input  fdvs_pkg::desc_t desc,
  input  fdvs_pkg::best_t best,
  output logic            beats
);

  logic more_cstr;

  assign more_cstr = desc.constraint_count > best.constraints;

  always_comb begin
    case (heuristic)
      fdvs_pkg::HEUR_FIRST_FAIL: beats = desc.domain_size < best.size;
      fdvs_pkg::HEUR_MOST_CSTR: beats = (desc.domain_size < best.size) ||
                                        ((desc.domain_size == best.size) && more_cstr);
      fdvs_pkg::HEUR_SMALLEST: beats = (desc.min_value < best.min_value) ||
                                       ((desc.min_value == best.min_value) && more_cstr);
      fdvs_pkg::HEUR_LARGEST: beats = (desc.max_value > best.max_value) ||
                                      ((desc.max_value == best.max_value) && more_cstr);
      fdvs_pkg::HEUR_MAX_REGRET: beats = (desc.regret_gap > best.gap) ||
                                         ((desc.regret_gap == best.gap) && more_cstr);
      default: beats = 1'b0;
    endcase
  end

endmodule

// ===== src/fdvs_tracker.sv =====
// ----------------------------------------------------------------------------
// fdvs_tracker
// Holds the running best candidate and the stream position of one array.
// ----------------------------------------------------------------------------
module fdvs_tracker #(
  parameter int MAX_VARS = 1024
) (
  input  logic            clk,
  input  logic            rst,
  input  fdvs_pkg::heur_t heuristic,
  input  logic            step,
  input  fdvs_pkg::desc_t desc,
  output fdvs_pkg::res_t  res
);

  localparam int CAP_INT = ((MAX_VARS - 1) < int'(fdvs_pkg::IDX_MAX)) ?
                           (MAX_VARS - 1) : int'(fdvs_pkg::IDX_MAX);
  localparam fdvs_pkg::idx_t IDX_CAP = fdvs_pkg::idx_t'(CAP_INT);

  fdvs_pkg::idx_t  position;
  logic            have_best;
  fdvs_pkg::idx_t  best_index;
  fdvs_pkg::best_t best;
  logic            beats;
  logic            take;

  fdvs_beats u_beats (
    .heuristic (heuristic),
    .desc      (desc),
    .best      (best),
    .beats     (beats)
  );

  assign take = !desc.is_ground && (!have_best || beats);

  always_comb begin
    res.found = have_best || !desc.is_ground;
    if (take) begin
      res.index = position;
    end else if (have_best) begin
      res.index = best_index;
    end else begin
      res.index = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position  <= '0;
      have_best <= 1'b0;
    end else if (step) begin
      if (desc.last_var) begin
        position  <= '0;
        have_best <= 1'b0;
      end else begin
        if (take) begin
          have_best <= 1'b1;
        end
        if (position < IDX_CAP) begin
          position <= position + fdvs_pkg::idx_t'(1);
        end
      end
    end
  end

  // candidate payload
  always_ff @(posedge clk) begin
    if (step && take) begin
      best_index       <= position;
      best.size        <= desc.domain_size;
      best.min_value   <= desc.min_value;
      best.max_value   <= desc.max_value;
      best.constraints <= desc.constraint_count;
      best.gap         <= desc.regret_gap;
    end
  end

endmodule
